### src/multi_pattern_first_match_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the multi-pattern first-match block
// Property checks compile in simulation and compile away in synthesis.
// ----------------------------------------------------------------------------
`ifndef MULTI_PATTERN_FIRST_MATCH_TOP_ASSERT_SVH
`define MULTI_PATTERN_FIRST_MATCH_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define MPFM_ASSERT_IMPL(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("mpfm: same-cycle check failed");
`define MPFM_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("mpfm: next-cycle check failed");
`else
`define MPFM_ASSERT_IMPL(name, ante, cons)
`define MPFM_ASSERT_NEXT(name, ante, cons)
`endif
`endif

### src/mpfm_pkg.sv
// ----------------------------------------------------------------------------
// Multi-pattern first-match package
// Shared constants, register codes and cell interface types.
// ----------------------------------------------------------------------------
`default_nettype none

package mpfm_pkg;

	localparam int MAX_PATTERNS        = 4;
	localparam int MAX_PATTERN_LEN_DEF = 8;
	localparam int OFFSET_BITS_DEF     = 16;

	localparam int NUM_PAT_REGS = 4;
	localparam int NUM_LANES    = (MAX_PATTERNS < NUM_PAT_REGS) ? MAX_PATTERNS : NUM_PAT_REGS;

	localparam int BYTE_W         = 8;
	localparam int CFG_DATA_W     = 64;
	localparam int CFG_INDEX_W    = 3;
	localparam int LEN_FIELD_W    = 4;
	localparam int LENGTHS_W      = 16;
	localparam int COUNT_W        = 3;
	localparam int MATCH_OFFSET_W = 16;

	localparam logic [LENGTHS_W-1:0] LENGTHS_RESET = 16'h1111;
	localparam logic [COUNT_W-1:0]   COUNT_RESET   = 3'd1;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_PATTERN_0 = 3'd0,
		REG_PATTERN_1 = 3'd1,
		REG_PATTERN_2 = 3'd2,
		REG_PATTERN_3 = 3'd3,
		REG_LENGTHS   = 3'd4,
		REG_COUNT     = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		logic [NUM_LANES-1:0][BYTE_W-1:0] pat_byte;
		logic [NUM_LANES-1:0]             ends_here;
	} cell_cfg_t;

	typedef struct packed {
		logic              shift;
		logic              flush;
		logic [BYTE_W-1:0] data;
	} cell_step_t;

endpackage

`default_nettype wire

### src/mpfm_cfg_regs.sv
// ----------------------------------------------------------------------------
// Configuration registers
// Holds the pattern bytes, lengths and count, and hands each cell its slice.
// ----------------------------------------------------------------------------
`default_nettype none

module mpfm_cfg_regs #(
	parameter int PAT_LEN = mpfm_pkg::MAX_PATTERN_LEN_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [mpfm_pkg::CFG_INDEX_W-1:0]      cfg_index,
	input  logic [mpfm_pkg::CFG_DATA_W-1:0]       cfg_data,
	output mpfm_pkg::cell_cfg_t [PAT_LEN-1:0]     cell_cfg
);

	localparam int PAT_W = mpfm_pkg::BYTE_W * PAT_LEN;
	localparam int LW    = mpfm_pkg::LEN_FIELD_W;

	logic [mpfm_pkg::NUM_LANES-1:0][PAT_W-1:0] pattern_q;
	logic [mpfm_pkg::LENGTHS_W-1:0]            lengths_q;
	logic [mpfm_pkg::COUNT_W-1:0]              count_q;
	logic [mpfm_pkg::NUM_LANES-1:0][LW-1:0]    len_sat;
	logic [mpfm_pkg::NUM_LANES-1:0]            lane_active;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_q <= '0;
			lengths_q <= mpfm_pkg::LENGTHS_RESET;
			count_q   <= mpfm_pkg::COUNT_RESET;
		end else if (cfg_we) begin
			for (int p = 0; p < mpfm_pkg::NUM_LANES; p++) begin
				if (cfg_index == mpfm_pkg::CFG_INDEX_W'(int'(mpfm_pkg::REG_PATTERN_0) + p)) begin
					pattern_q[p] <= cfg_data[PAT_W-1:0];
				end
			end
			if (cfg_index == mpfm_pkg::REG_LENGTHS) begin
				lengths_q <= cfg_data[mpfm_pkg::LENGTHS_W-1:0];
			end
			if (cfg_index == mpfm_pkg::REG_COUNT) begin
				count_q <= cfg_data[mpfm_pkg::COUNT_W-1:0];
			end
		end
	end

	always_comb begin
		for (int p = 0; p < mpfm_pkg::NUM_LANES; p++) begin
			len_sat[p] = (lengths_q[LW*p +: LW] > LW'(PAT_LEN)) ? LW'(PAT_LEN)
				: lengths_q[LW*p +: LW];
			lane_active[p] = (count_q > mpfm_pkg::COUNT_W'(p));
		end
	end

	always_comb begin
		for (int j = 0; j < PAT_LEN; j++) begin
			for (int p = 0; p < mpfm_pkg::NUM_LANES; p++) begin
				cell_cfg[j].pat_byte[p]  = pattern_q[p][mpfm_pkg::BYTE_W*j +: mpfm_pkg::BYTE_W];
				cell_cfg[j].ends_here[p] = lane_active[p] && (len_sat[p] == LW'(j + 1));
			end
		end
	end

endmodule

`default_nettype wire

### src/mpfm_cell.sv
// ----------------------------------------------------------------------------
// Match cell
// Tracks, for every pattern, a prefix match of its own length ending at the
// newest byte, and whether a whole pattern has matched from its start offset.
// ----------------------------------------------------------------------------
`default_nettype none

module mpfm_cell (
	input  logic                               clk,
	input  logic                               arst_n,
	input  mpfm_pkg::cell_step_t               step,
	input  mpfm_pkg::cell_cfg_t                cfg,
	input  logic [mpfm_pkg::NUM_LANES-1:0]     pm_in,
	input  logic                               hit_in,
	output logic [mpfm_pkg::NUM_LANES-1:0]     pm_q,
	output logic                               hit_q,
	output logic                               hit_nxt
);

	logic [mpfm_pkg::NUM_LANES-1:0] pm_nxt;

	always_comb begin
		for (int p = 0; p < mpfm_pkg::NUM_LANES; p++) begin
			pm_nxt[p] = pm_in[p] && (step.data == cfg.pat_byte[p]);
		end
		hit_nxt = hit_in || (|(pm_nxt & cfg.ends_here));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pm_q  <= '0;
			hit_q <= 1'b0;
		end else if (step.shift) begin
			if (step.flush) begin
				pm_q  <= '0;
				hit_q <= 1'b0;
			end else begin
				pm_q  <= pm_nxt;
				hit_q <= hit_nxt;
			end
		end
	end

endmodule

`default_nettype wire

### src/multi_pattern_first_match_top.sv
// ----------------------------------------------------------------------------
// Multi-pattern first-match search
// Streams a text one byte per beat and reports, on the final byte, whether
// any configured pattern occurs and the smallest start offset.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake            Payload
// text      in         text_valid/stall     text_byte, last_byte
// result    out        result_valid/stall   found, match_offset
// cfg       in         cfg_valid/ready      cfg_index, cfg_data
//
// One text beat is taken per cycle; a row of MAX_PATTERN_LEN cells matches
// every incoming byte against all pattern bytes in the cycle it arrives.
// The result is registered at the edge that takes the final byte and is
// offered from the next cycle on.
// Text beats keep flowing while a result waits; only a final byte stalls,
// and only while the result register is full and stalled.
// Reset clears the search state and loads the register reset values.
//
`default_nettype none

module multi_pattern_first_match_top #(
	parameter int MAX_PATTERN_LEN = mpfm_pkg::MAX_PATTERN_LEN_DEF,
	parameter int OFFSET_BITS     = mpfm_pkg::OFFSET_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  text_valid,
	output logic                                  text_stall,
	input  logic [mpfm_pkg::BYTE_W-1:0]           text_byte,
	input  logic                                  last_byte,
	output logic                                  result_valid,
	input  logic                                  result_stall,
	output logic                                  found,
	output logic [mpfm_pkg::MATCH_OFFSET_W-1:0]   match_offset,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [mpfm_pkg::CFG_INDEX_W-1:0]      cfg_index,
	input  logic [mpfm_pkg::CFG_DATA_W-1:0]       cfg_data
);

	`include "multi_pattern_first_match_top_assert.svh"

	localparam int L     = MAX_PATTERN_LEN;
	localparam int OB    = OFFSET_BITS;
	localparam int MOW   = mpfm_pkg::MATCH_OFFSET_W;
	localparam int SEL_W = (L > 1) ? $clog2(L) : 1;
	localparam logic [OB-1:0] POS_MAX = '1;

	mpfm_pkg::cell_cfg_t [L-1:0]          cell_cfg;
	mpfm_pkg::cell_step_t                 step;
	logic [L-1:0][mpfm_pkg::NUM_LANES-1:0] pm_q;
	logic [L-1:0]                         hit_q;
	logic [L-1:0]                         hit_nxt;

	logic              text_fire;
	logic              exact;
	logic              search_ok;
	logic              early_rec;
	logic [SEL_W-1:0]  sel;
	logic [OB-1:0]     cand_off;
	logic              res_found;
	logic [OB-1:0]     res_off;
	logic [OB+MOW-1:0] off_ext;

	logic [OB-1:0]     pos_q;
	logic              seen_q;
	logic [OB-1:0]     first_q;
	logic              res_valid_q;
	logic              found_q;
	logic [MOW-1:0]    offset_q;

	assign cfg_ready  = 1'b1;
	assign text_stall = res_valid_q && result_stall && last_byte;
	assign text_fire  = text_valid && !text_stall;

	assign step.shift = text_fire;
	assign step.flush = last_byte;
	assign step.data  = text_byte;

	mpfm_cfg_regs #(
		.PAT_LEN(L)
	) u_cfg_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_valid && cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.cell_cfg (cell_cfg)
	);

	for (genvar j = 0; j < L; j++) begin : g_cell
		if (j == 0) begin : g_head
			mpfm_cell u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.step   (step),
				.cfg    (cell_cfg[j]),
				.pm_in  ({mpfm_pkg::NUM_LANES{1'b1}}),
				.hit_in (1'b0),
				.pm_q   (pm_q[j]),
				.hit_q  (hit_q[j]),
				.hit_nxt(hit_nxt[j])
			);
		end else begin : g_body
			mpfm_cell u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.step   (step),
				.cfg    (cell_cfg[j]),
				.pm_in  (pm_q[j-1]),
				.hit_in (hit_q[j-1]),
				.pm_q   (pm_q[j]),
				.hit_q  (hit_q[j]),
				.hit_nxt(hit_nxt[j])
			);
		end
	end

	// The highest cell with a hit holds the oldest start offset.
	always_comb begin
		sel = '0;
		for (int j = 0; j < L; j++) begin
			if (hit_nxt[j]) begin
				sel = SEL_W'(j);
			end
		end
		exact     = (pos_q != POS_MAX);
		search_ok = exact && !seen_q;
		early_rec = search_ok && hit_nxt[L-1];
		cand_off  = pos_q - OB'(sel);
		res_found = seen_q || (search_ok && (|hit_nxt));
		res_off   = seen_q ? first_q : cand_off;
		off_ext   = (OB+MOW)'(res_off);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			seen_q  <= 1'b0;
			first_q <= '0;
		end else if (text_fire) begin
			if (last_byte) begin
				pos_q   <= '0;
				seen_q  <= 1'b0;
				first_q <= '0;
			end else begin
				if (exact) begin
					pos_q <= pos_q + OB'(1);
				end
				if (early_rec) begin
					seen_q  <= 1'b1;
					first_q <= cand_off;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (text_fire && last_byte) begin
			res_valid_q <= 1'b1;
		end else if (!result_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (text_fire && last_byte) begin
			found_q  <= res_found;
			offset_q <= res_found ? off_ext[MOW-1:0] : '0;
		end
	end

	assign result_valid = res_valid_q;
	assign found        = found_q;
	assign match_offset = offset_q;

	`MPFM_ASSERT_NEXT(a_flush_clears, text_fire && last_byte, pos_q == '0 && !seen_q)
	`MPFM_ASSERT_IMPL(a_no_find_zero_offset, res_valid_q && !found_q, offset_q == '0)
	`MPFM_ASSERT_NEXT(a_first_holds, seen_q && !(text_fire && last_byte), seen_q && $stable(first_q))
	`MPFM_ASSERT_IMPL(a_first_behind_pos, seen_q, first_q < pos_q)

endmodule

`default_nettype wire

### test/multi_pattern_first_match_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multi-pattern first-match search testbench
// Streams texts into the search block and computes the expected report for
// every text with an independent model of the byte window. Directed texts
// cover the register reset values, pattern lengths and counts. Random texts
// with planted patterns then run under sender idling and receiver stalls.
// ----------------------------------------------------------------------------

module multi_pattern_first_match_top_test;

	localparam int CLK_PERIOD  = 10;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int WINDOW_LEN  = mpfm_pkg::MAX_PATTERN_LEN_DEF;
	localparam int POS_LIMIT   = (1 << mpfm_pkg::OFFSET_BITS_DEF) - 1;
	localparam int PHASE_BYTES = 388;

	localparam logic [mpfm_pkg::CFG_INDEX_W-1:0] REG_UNUSED_6 = 3'd6;
	localparam logic [mpfm_pkg::CFG_INDEX_W-1:0] REG_UNUSED_7 = 3'd7;

	typedef struct packed {
		logic                                found;
		logic [mpfm_pkg::MATCH_OFFSET_W-1:0] offset;
	} match_report_t;

	logic                                clk          = 1'b0;
	logic                                arst_n       = 1'b0;
	logic                                text_valid   = 1'b0;
	logic                                text_stall;
	logic [mpfm_pkg::BYTE_W-1:0]         text_byte    = '0;
	logic                                last_byte    = 1'b0;
	logic                                result_valid;
	logic                                result_stall = 1'b0;
	logic                                found;
	logic [mpfm_pkg::MATCH_OFFSET_W-1:0] match_offset;
	logic                                cfg_valid    = 1'b0;
	logic                                cfg_ready;
	logic [mpfm_pkg::CFG_INDEX_W-1:0]    cfg_index    = '0;
	logic [mpfm_pkg::CFG_DATA_W-1:0]     cfg_data     = '0;

	logic [mpfm_pkg::CFG_DATA_W-1:0] pattern_words [mpfm_pkg::NUM_PAT_REGS];
	logic [mpfm_pkg::LENGTHS_W-1:0]  length_field;
	logic [mpfm_pkg::COUNT_W-1:0]    active_field;

	logic [mpfm_pkg::BYTE_W-1:0] win_bytes [WINDOW_LEN];
	int                          text_pos;
	logic                        hit_seen;
	int                          hit_offset;

	match_report_t expected_reports[$];
	match_report_t head_report;
	logic [mpfm_pkg::BYTE_W-1:0] text_buf[$];
	logic [mpfm_pkg::BYTE_W-1:0] alphabet [3];

	int idle_pct    = 0;
	int stall_pct   = 0;
	int bytes_sent  = 0;
	int errors      = 0;
	int cycle_count = 0;

	multi_pattern_first_match_top uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.text_valid   (text_valid),
		.text_stall   (text_stall),
		.text_byte    (text_byte),
		.last_byte    (last_byte),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.found        (found),
		.match_offset (match_offset),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d reports outstanding", $time,
				expected_reports.size());
			$display("FAIL multi_pattern_first_match_top");
			$finish;
		end
	end

	always @(posedge clk) begin
		result_stall <= ($urandom_range(99) < stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			if (expected_reports.size() == 0) begin
				$display("%0t: unexpected report, expected none, actual found %0b offset %0d",
					$time, found, match_offset);
				errors++;
			end else begin
				head_report = expected_reports.pop_front();
				if (found !== head_report.found) begin
					$display("%0t: found mismatch, expected %0b, actual %0b", $time,
						head_report.found, found);
					errors++;
				end
				if (match_offset !== head_report.offset) begin
					$display("%0t: match_offset mismatch, expected %0d, actual %0d", $time,
						head_report.offset, match_offset);
					errors++;
				end
			end
		end
	end

	function automatic void clear_search();
		for (int k = 0; k < WINDOW_LEN; k++) begin
			win_bytes[k] = '0;
		end
		text_pos   = 0;
		hit_seen   = 1'b0;
		hit_offset = 0;
	endfunction

	function automatic void apply_setting(logic [mpfm_pkg::CFG_INDEX_W-1:0] index,
		logic [mpfm_pkg::CFG_DATA_W-1:0] value);
		unique case (index)
			mpfm_pkg::REG_PATTERN_0, mpfm_pkg::REG_PATTERN_1,
			mpfm_pkg::REG_PATTERN_2, mpfm_pkg::REG_PATTERN_3: begin
				pattern_words[index[1:0]] = value;
			end
			mpfm_pkg::REG_LENGTHS: begin
				length_field = value[mpfm_pkg::LENGTHS_W-1:0];
			end
			mpfm_pkg::REG_COUNT: begin
				active_field = value[mpfm_pkg::COUNT_W-1:0];
			end
			default: begin
			end
		endcase
	endfunction

	function automatic int pattern_length(int p);
		int len;
		len = length_field[mpfm_pkg::LEN_FIELD_W*p +: mpfm_pkg::LEN_FIELD_W];
		if (len > WINDOW_LEN) len = WINDOW_LEN;
		return len;
	endfunction

	// True when any active pattern starts at offset off, where cur is the
	// index of the newest byte in the window.
	function automatic logic pattern_hits(int cur, int off, logic fit_only);
		int   n;
		int   back;
		int   len;
		logic ok;
		logic hit;
		hit = 1'b0;
		n = active_field;
		if (n > mpfm_pkg::MAX_PATTERNS) n = mpfm_pkg::MAX_PATTERNS;
		if (n > mpfm_pkg::NUM_PAT_REGS) n = mpfm_pkg::NUM_PAT_REGS;
		back = cur - off;
		if (off <= cur && back < WINDOW_LEN) begin
			for (int p = 0; p < n; p++) begin
				len = pattern_length(p);
				if (len != 0 && !(fit_only && off + len - 1 > cur)) begin
					ok = 1'b1;
					for (int k = 0; k < len; k++) begin
						if (k > back) begin
							ok = 1'b0;
						end else if (win_bytes[back - k] !=
							pattern_words[p][mpfm_pkg::BYTE_W*k +: mpfm_pkg::BYTE_W]) begin
							ok = 1'b0;
						end
					end
					if (ok) hit = 1'b1;
				end
			end
		end
		return hit;
	endfunction

	function automatic void search_step(logic [mpfm_pkg::BYTE_W-1:0] value, logic is_last);
		int            cur;
		logic          exact;
		int            off;
		match_report_t report;
		cur = text_pos;
		exact = (cur < POS_LIMIT);
		for (int k = WINDOW_LEN - 1; k > 0; k--) begin
			win_bytes[k] = win_bytes[k - 1];
		end
		win_bytes[0] = value;
		if (text_pos < POS_LIMIT) text_pos++;
		if (exact && !hit_seen && cur + 1 >= WINDOW_LEN) begin
			off = cur + 1 - WINDOW_LEN;
			if (pattern_hits(cur, off, 1'b0)) begin
				hit_seen   = 1'b1;
				hit_offset = off;
			end
		end
		if (is_last) begin
			if (exact && !hit_seen) begin
				off = (cur + 1 >= WINDOW_LEN) ? cur + 2 - WINDOW_LEN : 0;
				while (off <= cur && !hit_seen) begin
					if (pattern_hits(cur, off, 1'b1)) begin
						hit_seen   = 1'b1;
						hit_offset = off;
					end
					off++;
				end
			end
			report.found  = hit_seen;
			report.offset = hit_seen ? hit_offset[mpfm_pkg::MATCH_OFFSET_W-1:0] : '0;
			expected_reports.insert(expected_reports.size(), report);
			clear_search();
		end
	endfunction

	task automatic send_byte(input logic [mpfm_pkg::BYTE_W-1:0] value, input logic is_last);
		if ($urandom_range(99) < idle_pct) begin
			text_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < idle_pct);
		end
		text_valid <= 1'b1;
		text_byte  <= value;
		last_byte  <= is_last;
		do @(posedge clk); while (text_stall);
		search_step(value, is_last);
		bytes_sent++;
	endtask

	task automatic send_text();
		for (int i = 0; i < text_buf.size(); i++) begin
			send_byte(text_buf[i], i == text_buf.size() - 1);
		end
	endtask

	task automatic load_text(input logic [mpfm_pkg::CFG_DATA_W-1:0] bytes, input int count);
		text_buf.delete();
		for (int k = 0; k < count; k++) begin
			text_buf.insert(text_buf.size(), bytes[mpfm_pkg::BYTE_W*k +: mpfm_pkg::BYTE_W]);
		end
	endtask

	task automatic drain_results();
		text_valid <= 1'b0;
		@(posedge clk);
		while (expected_reports.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_setting(input logic [mpfm_pkg::CFG_INDEX_W-1:0] index,
		input logic [mpfm_pkg::CFG_DATA_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		apply_setting(index, value);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic write_random_settings();
		logic [mpfm_pkg::CFG_DATA_W-1:0] value;
		logic [mpfm_pkg::LENGTHS_W-1:0]  lens;
		for (int k = 0; k < 3; k++) begin
			alphabet[k] = mpfm_pkg::BYTE_W'($urandom);
		end
		for (int p = 0; p < mpfm_pkg::NUM_PAT_REGS; p++) begin
			value = '0;
			if ($urandom_range(9) == 0) begin
				value = $urandom_range(1) ? '1 : '0;
			end else begin
				for (int k = 0; k < WINDOW_LEN; k++) begin
					value[mpfm_pkg::BYTE_W*k +: mpfm_pkg::BYTE_W] =
						($urandom_range(3) != 0) ? alphabet[$urandom_range(2)]
						: mpfm_pkg::BYTE_W'($urandom);
				end
			end
			write_setting(mpfm_pkg::cfg_reg_t'(p), value);
		end
		for (int p = 0; p < mpfm_pkg::NUM_PAT_REGS; p++) begin
			lens[mpfm_pkg::LEN_FIELD_W*p +: mpfm_pkg::LEN_FIELD_W] =
				mpfm_pkg::LEN_FIELD_W'(($urandom_range(9) < 8) ?
				$urandom_range(1, WINDOW_LEN) : $urandom_range(15));
		end
		if ($urandom_range(19) == 0) lens = $urandom_range(1) ? '1 : '0;
		write_setting(mpfm_pkg::REG_LENGTHS, mpfm_pkg::CFG_DATA_W'(lens));
		write_setting(mpfm_pkg::REG_COUNT, mpfm_pkg::CFG_DATA_W'(($urandom_range(9) < 8) ?
			$urandom_range(1, mpfm_pkg::MAX_PATTERNS) : $urandom_range(7)));
	endtask

	task automatic build_random_text();
		int len;
		int off;
		int p;
		int plen;
		text_buf.delete();
		len = ($urandom_range(99) < 85) ? $urandom_range(1, 16) : $urandom_range(17, 48);
		for (int k = 0; k < len; k++) begin
			text_buf.insert(text_buf.size(), ($urandom_range(99) < 60) ?
				alphabet[$urandom_range(2)] : mpfm_pkg::BYTE_W'($urandom));
		end
		if ($urandom_range(99) < 70) begin
			p = $urandom_range(mpfm_pkg::NUM_PAT_REGS - 1);
			plen = pattern_length(p);
			if (plen == 0) plen = 1;
			off = $urandom_range(len - 1);
			for (int k = 0; k < plen && off + k < len; k++) begin
				text_buf[off + k] = pattern_words[p][mpfm_pkg::BYTE_W*k +: mpfm_pkg::BYTE_W];
			end
		end
	endtask

	task automatic test_reset_values();
		load_text(64'h00, 1);
		send_text();
		load_text(64'h00FF, 2);
		send_text();
		drain_results();
	endtask

	task automatic test_directed_patterns();
		write_setting(mpfm_pkg::REG_PATTERN_0, 64'h0000_0000_0000_6261);
		write_setting(mpfm_pkg::REG_PATTERN_1, 64'hFFFF_FFFF_FFFF_FFFF);
		write_setting(mpfm_pkg::REG_PATTERN_2, 64'h0807_0605_0403_0201);
		write_setting(mpfm_pkg::REG_PATTERN_3, 64'h0000_0000_0000_0063);
		write_setting(mpfm_pkg::REG_LENGTHS, 64'h0F82);
		write_setting(mpfm_pkg::REG_COUNT, 64'h7);
		write_setting(REG_UNUSED_6, '1);
		write_setting(REG_UNUSED_7, '1);
		load_text(64'h63, 1);
		send_text();
		load_text(64'h626178, 3);
		send_text();
		// A partial pattern at the end of one text must not join the next.
		load_text(64'h617A, 2);
		send_text();
		load_text(64'h62, 1);
		send_text();
		load_text('1, WINDOW_LEN);
		text_buf.push_front(8'h7A);
		send_text();
		drain_results();
		write_setting(mpfm_pkg::REG_COUNT, 64'h0);
		load_text(64'h6261, 2);
		send_text();
		drain_results();
		write_setting(mpfm_pkg::REG_COUNT, 64'h4);
		write_setting(mpfm_pkg::REG_LENGTHS, 64'h0000);
		load_text(64'h6261, 2);
		send_text();
		drain_results();
		write_setting(mpfm_pkg::REG_LENGTHS, 64'hFFFF);
		load_text(64'h6261, WINDOW_LEN);
		send_text();
		drain_results();
	endtask

	task automatic test_random_traffic(input int sender_idle, input int receiver_stall);
		int target;
		int texts;
		idle_pct  = sender_idle;
		stall_pct = receiver_stall;
		target = bytes_sent + PHASE_BYTES;
		texts = 0;
		while (bytes_sent < target) begin
			if (texts % 8 == 0) begin
				drain_results();
				write_random_settings();
			end
			build_random_text();
			send_text();
			texts++;
		end
		drain_results();
		idle_pct  = 0;
		stall_pct = 0;
	endtask

	initial begin
		for (int p = 0; p < mpfm_pkg::NUM_PAT_REGS; p++) begin
			pattern_words[p] = '0;
		end
		length_field = mpfm_pkg::LENGTHS_RESET;
		active_field = mpfm_pkg::COUNT_RESET;
		clear_search();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		test_reset_values();
		test_directed_patterns();
		test_random_traffic(0, 0);
		test_random_traffic(81, 0);
		test_random_traffic(0, 81);
		test_random_traffic(36, 36);
		if (errors == 0) begin
			$display("PASS multi_pattern_first_match_top");
		end else begin
			$display("FAIL multi_pattern_first_match_top");
		end
		$finish;
	end

endmodule
